[src/mme_pkg.sv]
// shared types and constants for the matrix multiply engine
`timescale 1ns / 1ps
`default_nettype none
package mme_pkg;

  localparam int MME_MAX_DIM    = 16;
  localparam int MME_DATA_WIDTH = 32;
  localparam int FRAC_BITS      = 16;
  localparam int INDEX_CAP      = 16;

  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 4;
  localparam int ELEM_W   = 32;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } mme_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_FIRST  = 2'd0,
    REG_INNER_SIZE  = 2'd1,
    REG_COLS_SECOND = 2'd2
  } mme_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } mme_state_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mme_mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mme_mac_stat_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] col;
    logic             last;
  } mme_emit_t;

endpackage
`default_nettype wire

[src/mme_if.sv]
// stream interfaces for command words and result words
`timescale 1ns / 1ps
`default_nettype none
interface mme_in_if
  import mme_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mme_out_if
  import mme_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] result_value;
  logic [IDX_W-1:0]         result_col;
  logic                     saturated;
  logic                     last;

  modport source (output valid, result_value, result_col, saturated, last, input ready);
  modport sink (input valid, result_value, result_col, saturated, last, output ready);
endinterface
`default_nettype wire

[src/matrix_multiply_engine.sv]
// top level of the matrix multiply engine
// Usage: command words arrive on item. opcode load A / load B write one element
// at (row_index, col_index); out-of-range loads are dropped. A compute word
// names a result row and the block emits cols_second (capped at 16) result
// words on result, columns in order, last set on the final one; a row
// outside rows_first gives no words. Sizes are set through cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce this. After a load, item is
// ready again the next cycle. A compute puts every product through the one
// shared multiplier, one inner index per cycle; each column then waits for
// the multiply pipeline to drain and for the output register to be free
// before its word goes out; with inner_size zero no product is issued.
// item is not ready while a row is being computed.
// Stall: the output register holds a word until taken; the sequencer waits
// before handing over the next column, and a new command can be taken while
// the final word of a row still waits.
// Reset: sizes return to 10 each, item is not ready and the output goes empty;
// matrix contents are not cleared and read as unknown until loaded.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = MME_MAX_DIM,
  parameter int DATA_WIDTH = MME_DATA_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  mme_in_if.sink                    item,
  mme_out_if.source                 result
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam logic [CFG_W-1:0] CAP = CFG_W'((MAX_DIM < INDEX_CAP) ? MAX_DIM : INDEX_CAP);

  logic [CFG_W-1:0] rows_first, inner_size, cols_second;
  logic [CFG_W-1:0] nr, nk, nc;

  logic                  a_we, b_we;
  logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
  logic [DATA_WIDTH-1:0] a_data, b_data;

  mme_mac_ctrl_t           mac_ctrl;
  mme_mac_stat_t           mac_stat;
  mme_emit_t               emit;
  logic signed [ELEM_W-1:0] mac_value;
  logic                    mac_sat;
  logic                    out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_first  <= SIZE_RESET;
      inner_size  <= SIZE_RESET;
      cols_second <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_FIRST:  rows_first  <= cfg_data;
        REG_INNER_SIZE:  inner_size  <= cfg_data;
        REG_COLS_SECOND: cols_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr = (rows_first  > CAP) ? CAP : rows_first;
  assign nk = (inner_size  > CAP) ? CAP : inner_size;
  assign nc = (cols_second > CAP) ? CAP : cols_second;

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (item.element_value[DATA_WIDTH-1:0]),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (item.element_value[DATA_WIDTH-1:0]),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .opcode    (item.opcode),
    .row_index (item.row_index),
    .col_index (item.col_index),
    .nr        (nr),
    .nk        (nk),
    .nc        (nc),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .mac_ctrl  (mac_ctrl),
    .mac_stat  (mac_stat),
    .out_free  (out_free),
    .emit      (emit)
  );

  mme_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mac_ctrl),
    .stat         (mac_stat),
    .a_data       (a_data),
    .b_data       (b_data),
    .result_value (mac_value),
    .saturated    (mac_sat)
  );

  // output word register
  assign out_free = ~result.valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit.valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (emit.valid) begin
      result.result_value <= mac_value;
      result.result_col   <= emit.col;
      result.saturated    <= mac_sat;
      result.last         <= emit.last;
    end
  end

endmodule
`default_nettype wire

[src/mme_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/mme_mac.sv]
// shared multiply-accumulate unit with truncation and saturation
`timescale 1ns / 1ps
`default_nettype none
module mme_mac
  import mme_pkg::*;
#(
  parameter int DATA_WIDTH = MME_DATA_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mme_mac_ctrl_t           ctrl,
  output mme_mac_stat_t                stat,
  input  wire logic [DATA_WIDTH-1:0]   a_data,
  input  wire logic [DATA_WIDTH-1:0]   b_data,
  output logic signed [ELEM_W-1:0]     result_value,
  output logic                         saturated
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int TOP_LO = FRAC_BITS + DATA_WIDTH - 1;
  // room for a sum of INDEX_CAP products, and at least the sign of the truncated sum
  localparam int SUM_W  = PROD_W + $clog2(INDEX_CAP) + 1;
  localparam int ACC_W  = (SUM_W > TOP_LO) ? SUM_W : TOP_LO + 1;

  logic                     data_valid;
  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [ACC_W-1:TOP_LO]        acc_top;
  logic                         fits;
  logic signed [DATA_WIDTH-1:0] clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      data_valid <= ctrl.issue;
      prod_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= signed'(a_data) * signed'(b_data);
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_comb begin
    acc_top = acc[ACC_W-1:TOP_LO];
    fits    = (&acc_top) | ~(|acc_top);
    if (fits) begin
      clamped = acc[TOP_LO:FRAC_BITS];
    end else if (acc[ACC_W-1]) begin
      clamped = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  assign result_value = ELEM_W'(clamped);
  assign saturated    = ~fits;
  assign stat.busy    = data_valid | prod_valid;

endmodule
`default_nettype wire

[src/mme_seq.sv]
// sequencer: element loads and the column / inner loop of a row compute
`timescale 1ns / 1ps
`default_nettype none
module mme_seq
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MME_MAX_DIM
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [OPCODE_W-1:0]                  opcode,
  input  wire logic [IDX_W-1:0]                     row_index,
  input  wire logic [IDX_W-1:0]                     col_index,
  input  wire logic [CFG_W-1:0]                     nr,
  input  wire logic [CFG_W-1:0]                     nk,
  input  wire logic [CFG_W-1:0]                     nc,
  output logic                                      a_we,
  output logic                                      b_we,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        waddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        a_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        b_raddr,
  output mme_mac_ctrl_t                             mac_ctrl,
  input  wire mme_mac_stat_t                        mac_stat,
  input  wire logic                                 out_free,
  output mme_emit_t                                 emit
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);

  mme_state_t       state, state_next;
  logic [IDX_W-1:0] row, row_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] j, j_next;

  logic row_in_nr, row_in_nk, col_in_nk, col_in_nc;
  logic k_last, j_last;

  assign waddr   = ADDR_W'(row_index) * DIM_A + ADDR_W'(col_index);
  assign a_raddr = ADDR_W'(row) * DIM_A + ADDR_W'(k);
  assign b_raddr = ADDR_W'(k) * DIM_A + ADDR_W'(j);

  assign row_in_nr = CFG_W'(row_index) < nr;
  assign row_in_nk = CFG_W'(row_index) < nk;
  assign col_in_nk = CFG_W'(col_index) < nk;
  assign col_in_nc = CFG_W'(col_index) < nc;
  assign k_last    = CFG_W'(k) == nk - CFG_W'(1);
  assign j_last    = CFG_W'(j) == nc - CFG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    row <= row_next;
    k   <= k_next;
    j   <= j_next;
  end

  always_comb begin
    state_next     = state;
    row_next       = row;
    k_next         = k;
    j_next         = j;
    in_ready       = 1'b0;
    a_we           = 1'b0;
    b_we           = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clear = 1'b0;
    emit.valid     = 1'b0;
    emit.col       = j;
    emit.last      = j_last;
    unique case (state)
      ST_IDLE: begin
        // no word is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          unique case (opcode)
            OP_LOAD_A:  a_we = row_in_nr & col_in_nk;
            OP_LOAD_B:  b_we = row_in_nk & col_in_nc;
            OP_COMPUTE: begin
              if (row_in_nr && nc != '0) begin
                row_next       = row_index;
                k_next         = '0;
                j_next         = '0;
                mac_ctrl.clear = 1'b1;
                state_next     = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        // an empty inner dimension gives a zero dot product
        if (nk == '0) begin
          state_next = ST_DRAIN;
        end else begin
          mac_ctrl.issue = 1'b1;
          if (k_last) begin
            k_next     = '0;
            state_next = ST_DRAIN;
          end else begin
            k_next = k + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land, then for room at the output
        if (!mac_stat.busy && out_free) begin
          emit.valid = 1'b1;
          if (j_last) begin
            state_next = ST_IDLE;
          end else begin
            j_next         = j + IDX_W'(1);
            mac_ctrl.clear = 1'b1;
            state_next     = ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[tb/sv/tb_matrix_multiply_engine.sv]
// testbench for matrix_multiply_engine: streams load and compute words, checks each result word
`timescale 1ns / 1ps
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 320;
  localparam int LONG_HOLD    = 400;
  localparam int STIM_WORDS   = 360;
  localparam int TIMEOUT_NS   = 5_000_000;

  // codes the package leaves unnamed; the block ignores both
  localparam logic [OPCODE_W-1:0]  OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [127:0] Q16_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q16_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  col;
    logic              sat;
    logic              last;
  } row_word_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mme_in_if  item_bus ();
  mme_out_if result_bus ();

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the block: sizes, both matrices, and which entries hold data
  logic [CFG_W-1:0]  size_rows  = SIZE_RESET;
  logic [CFG_W-1:0]  size_inner = SIZE_RESET;
  logic [CFG_W-1:0]  size_cols  = SIZE_RESET;
  logic [ELEM_W-1:0] mat_a [MME_MAX_DIM][MME_MAX_DIM];
  logic [ELEM_W-1:0] mat_b [MME_MAX_DIM][MME_MAX_DIM];
  bit                a_loaded [MME_MAX_DIM][MME_MAX_DIM];
  bit                b_loaded [MME_MAX_DIM][MME_MAX_DIM];

  row_word_t expected_row_words [$];
  int        errors = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  bit        hold_results = 1'b0;

  function automatic int dim_of(logic [CFG_W-1:0] v);
    int cap;
    cap = (MME_MAX_DIM < INDEX_CAP) ? MME_MAX_DIM : INDEX_CAP;
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  function automatic row_word_t row_dot(int r, int j, int n_k, int n_c);
    logic signed [127:0] acc;
    logic signed [63:0]  prod;
    row_word_t           w;
    acc = '0;
    for (int k = 0; k < n_k; k++) begin
      prod = $signed(mat_a[r][k]) * $signed(mat_b[k][j]);
      acc = acc + prod;
    end
    acc = acc >>> FRAC_BITS;  // drop fraction bits, rounds toward minus infinity
    w.sat = 1'b1;
    if (acc > Q16_MAX) begin
      w.value = Q16_MAX[ELEM_W-1:0];
    end else if (acc < Q16_MIN) begin
      w.value = Q16_MIN[ELEM_W-1:0];
    end else begin
      w.value = acc[ELEM_W-1:0];
      w.sat = 1'b0;
    end
    w.col = IDX_W'(j);
    w.last = (j == n_c - 1);
    return w;
  endfunction

  function automatic void track_command(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] row,
                                        logic [IDX_W-1:0] col, logic [ELEM_W-1:0] value);
    int n_r, n_k, n_c;
    n_r = dim_of(size_rows);
    n_k = dim_of(size_inner);
    n_c = dim_of(size_cols);
    case (op)
      OP_LOAD_A: if (row < n_r && col < n_k) begin
        mat_a[row][col] = value;
        a_loaded[row][col] = 1'b1;
      end
      OP_LOAD_B: if (row < n_k && col < n_c) begin
        mat_b[row][col] = value;
        b_loaded[row][col] = 1'b1;
      end
      OP_COMPUTE: if (row < n_r) begin
        for (int j = 0; j < n_c; j++) expected_row_words.push_back(row_dot(row, j, n_k, n_c));
      end
      default: ;
    endcase
  endfunction

  // a compute of row r may only touch entries that were loaded
  function automatic bit row_ready(int r);
    int n_k, n_c;
    n_k = dim_of(size_inner);
    n_c = dim_of(size_cols);
    if (r >= dim_of(size_rows) || n_c == 0) return 1'b1;
    for (int k = 0; k < n_k; k++) if (!a_loaded[r][k]) return 1'b0;
    for (int k = 0; k < n_k; k++)
      for (int j = 0; j < n_c; j++) if (!b_loaded[k][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;  // within +-4.0
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'd16;
      2: return CFG_W'($urandom_range(17, 31));
      3, 4: return CFG_W'($urandom_range(7, 15));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic pause_sender(int n);
    item_bus.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // called at a falling edge; leaves valid high so bursts run back to back
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [ELEM_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      if (gap > 0) pause_sender(gap);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_bus.valid         <= 1'b1;
    item_bus.opcode        <= op;
    item_bus.row_index     <= row;
    item_bus.col_index     <= col;
    item_bus.element_value <= value;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    track_command(op, row, col, value);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_compute(int r);
    send_word(OP_COMPUTE, IDX_W'(r), IDX_W'($urandom), $urandom);
  endtask

  task automatic load_missing(int r);
    int n_k, n_c;
    n_k = dim_of(size_inner);
    n_c = dim_of(size_cols);
    for (int k = 0; k < n_k; k++) if (!a_loaded[r][k]) begin
      send_word(OP_LOAD_A, IDX_W'(r), IDX_W'(k), rand_element());
      return;
    end
    for (int k = 0; k < n_k; k++)
      for (int j = 0; j < n_c; j++) if (!b_loaded[k][j]) begin
        send_word(OP_LOAD_B, IDX_W'(k), IDX_W'(j), rand_element());
        return;
      end
  endtask

  task automatic fill_row(int r);
    while (!row_ready(r)) load_missing(r);
  endtask

  task automatic wait_results();
    pause_sender(1);
    while (expected_row_words.size() != 0) @(negedge clk);
  endtask

  // loads leave nothing to wait for, so give the block a full row time on top
  task automatic wait_drained();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                           logic [CFG_W-1:0] cols);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_FIRST;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_index <= REG_INNER_SIZE;
    cfg_data  <= inner;
    @(negedge clk);
    cfg_index <= REG_COLS_SECOND;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    size_rows  = rows;
    size_inner = inner;
    size_cols  = cols;
  endtask

  task automatic test_reset_sizes();
    // sizes are 10 each out of reset
    fill_row(9);
    send_compute(9);
    send_compute(10);
  endtask

  task automatic test_directed();
    set_sizes(5'd2, 5'd2, 5'd2);
    // clamp high and low
    send_word(OP_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_LOAD_A, 4'd0, 4'd1, 32'h7FFF_FFFF);
    send_word(OP_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_LOAD_B, 4'd1, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_LOAD_B, 4'd0, 4'd1, 32'h8000_0000);
    send_word(OP_LOAD_B, 4'd1, 4'd1, 32'h8000_0000);
    send_compute(0);
    send_word(OP_LOAD_A, 4'd1, 4'd0, 32'h8000_0000);
    send_word(OP_LOAD_A, 4'd1, 4'd1, 32'h0000_0001);
    send_word(OP_COMPUTE, 4'd1, 4'd15, 32'hFFFF_FFFF);
    // loads outside the sizes and the spare opcode must leave the matrices alone
    send_word(OP_LOAD_A, 4'd2, 4'd0, 32'h1234_5678);
    send_word(OP_LOAD_A, 4'd0, 4'd2, 32'h1234_5678);
    send_word(OP_LOAD_B, 4'd2, 4'd0, 32'h1234_5678);
    send_word(OP_LOAD_B, 4'd0, 4'd2, 32'h1234_5678);
    send_word(OP_LOAD_A, 4'd15, 4'd15, 32'h1234_5678);
    send_word(OP_SPARE, 4'd0, 4'd0, 32'h1234_5678);
    send_compute(2);
    send_compute(15);
    send_compute(0);
    // smallest negative times positive: truncation goes down
    send_word(OP_LOAD_A, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_word(OP_LOAD_A, 4'd0, 4'd1, 32'h0000_0000);
    send_compute(0);
  endtask

  task automatic test_size_corners();
    set_sizes(5'd0, 5'd2, 5'd2);
    send_compute(0);
    send_compute(5);
    set_sizes(5'd2, 5'd2, 5'd0);
    send_compute(0);
    send_compute(1);
    set_sizes(5'd1, 5'd0, 5'd3);
    send_compute(0);
    set_sizes(5'd31, 5'd16, 5'd1);
    fill_row(15);
    send_compute(15);
    set_sizes(5'd16, 5'd1, 5'd31);
    fill_row(15);
    send_compute(15);
  endtask

  task automatic test_backpressure();
    set_sizes(5'd4, 5'd3, 5'd5);
    for (int r = 0; r < 4; r++) fill_row(r);
    hold_results = 1'b1;
    repeat (14) begin
      if ($urandom_range(0, 2) != 0) send_compute($urandom_range(0, 3));
      else send_word(OP_LOAD_B, IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 4)),
                     rand_element());
    end
    wait_results();
    repeat (6) send_compute($urandom_range(0, 3));
  endtask

  task automatic random_phase(int n_words);
    int                  n_r, n_k, n_c, r, kind;
    logic [OPCODE_W-1:0] op;
    logic [IDX_W-1:0]    row;
    set_sizes(pick_size(), pick_size(), pick_size());
    n_r = dim_of(size_rows);
    n_k = dim_of(size_inner);
    n_c = dim_of(size_cols);
    repeat (n_words) begin
      kind = $urandom_range(0, 99);
      r = (n_r == 0) ? 0 : $urandom_range(0, n_r - 1);
      if (kind < 60) begin
        if (row_ready(r)) send_compute(r);
        else load_missing(r);
      end else if (kind < 78) begin
        // overwrite an entry inside the current sizes
        if ($urandom_range(0, 1) == 0)
          send_word(OP_LOAD_A, IDX_W'(r), IDX_W'((n_k == 0) ? 0 : $urandom_range(0, n_k - 1)),
                    rand_element());
        else
          send_word(OP_LOAD_B, IDX_W'((n_k == 0) ? 0 : $urandom_range(0, n_k - 1)),
                    IDX_W'((n_c == 0) ? 0 : $urandom_range(0, n_c - 1)), rand_element());
      end else begin
        op = OPCODE_W'($urandom_range(0, 3));
        row = IDX_W'($urandom);
        if (op == OP_COMPUTE && !row_ready(row)) op = OP_SPARE;
        send_word(op, row, IDX_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_random();
    while (words_sent < STIM_WORDS) random_phase($urandom_range(20, 40));
  endtask

  // receiver: long hold on request, else ready always, at random, sparsely or mostly, in turn
  initial begin : result_pacer
    int unsigned cyc;
    int          hold_left;
    cyc = 0;
    hold_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_results && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_results = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: result_bus.ready <= 1'b1;
          1: result_bus.ready <= 1'($urandom_range(0, 1));
          2: result_bus.ready <= (cyc % 5 == 0);
          default: result_bus.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    row_word_t want;
    if (rst === 1'b0 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (expected_row_words.size() == 0) begin
        $error("result word with none expected: result_value %0d result_col %0d",
               result_bus.result_value, result_bus.result_col);
        errors++;
      end else begin
        want = expected_row_words.pop_front();
        if (result_bus.result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value),
                 result_bus.result_value);
          errors++;
        end
        if (result_bus.result_col !== want.col) begin
          $error("result_col: expected %0d, got %0d", want.col, result_bus.result_col);
          errors++;
        end
        if (result_bus.saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, result_bus.saturated);
          errors++;
        end
        if (result_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_bus.last);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ROWS_FIRST;
    cfg_data = '0;
    item_bus.valid = 1'b0;
    item_bus.opcode = OP_LOAD_A;
    item_bus.row_index = '0;
    item_bus.col_index = '0;
    item_bus.element_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_sizes();
    test_directed();
    test_size_corners();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("tb_matrix_multiply_engine: done, clean");
    end else begin
      $display("tb_matrix_multiply_engine: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_matrix_multiply_engine: done, errors");
    $finish;
  end

endmodule
